// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the 4x4 matrix multiply core.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mm4_pkg.sv
// Package of the 4x4 matrix multiply core: sizes, operation codes, item types.
// Used by the cells, the output stage and the top level.
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int NFIELD    = 4;
  localparam int NCELL     = (DIM < NFIELD) ? DIM : NFIELD;
  localparam int CIDX_W    = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int ROW_W     = 2;
  localparam int EL_W      = 32;
  localparam int PROD_W    = 2 * EL_W;
  localparam int ACC_W     = PROD_W + $clog2(NCELL);
  localparam int SH_W      = ACC_W - FRAC_BITS;

  localparam logic [EL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [EL_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MULT = 1'b1
  } op_t;

  typedef struct packed {
    logic                              valid;
    op_t                               op;
    logic [ROW_W-1:0]                  row;
    logic [NCELL-1:0][EL_W-1:0]        elem;
    logic [NCELL-1:0][ACC_W-1:0]       acc;
  } mm4_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]                  row;
    logic [NFIELD-1:0][EL_W-1:0]       e;
    logic                              sat;
  } mm4_res_t;

endpackage

// File: hw/rtl/mm4_if.sv
// Channel interfaces of the 4x4 matrix multiply core: row items in, product items out.
// Valid/ready handshake; no dependencies.
interface mm4_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [1:0]         row_index;
  logic signed [31:0] in_e0;
  logic signed [31:0] in_e1;
  logic signed [31:0] in_e2;
  logic signed [31:0] in_e3;

  modport source (output valid, operation, row_index, in_e0, in_e1, in_e2, in_e3,
                  input ready);
  modport sink   (input valid, operation, row_index, in_e0, in_e1, in_e2, in_e3,
                  output ready);
endinterface

interface mm4_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_row;
  logic signed [31:0] out_e0;
  logic signed [31:0] out_e1;
  logic signed [31:0] out_e2;
  logic signed [31:0] out_e3;
  logic               saturated;

  modport source (output valid, out_row, out_e0, out_e1, out_e2, out_e3, saturated,
                  input ready);
  modport sink   (input valid, out_row, out_e0, out_e1, out_e2, out_e3, saturated,
                  output ready);
endinterface

// File: hw/rtl/mm4_cell.sv
// One cell of the chain: holds one row of matrix A, multiplies it by one element
// of the passing item and adds to the running column sums. Depends on mm4_pkg.
`include "assert_macros.svh"

module mm4_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [mm4_pkg::CIDX_W-1:0] idx,
  input  mm4_pkg::mm4_item_t        din,
  output mm4_pkg::mm4_item_t        dout
);
  import mm4_pkg::*;

  mm4_item_t               s1;
  mm4_item_t               s2;
  logic signed [PROD_W-1:0] prod [NCELL];
  logic [EL_W-1:0]          a_row [NCELL];
  logic                     wr;

  assign wr = en && s1.valid && (s1.op == OP_LOAD) && (s1.row == ROW_W'(idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= din.valid;
      s2.valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.op   <= din.op;
      s1.row  <= din.row;
      s1.elem <= din.elem;
      s1.acc  <= din.acc;
      s2.op   <= s1.op;
      s2.row  <= s1.row;
      s2.elem <= s1.elem;
      s2.acc  <= s1.acc;
      for (int j = 0; j < NCELL; j++) begin
        prod[j] <= $signed(a_row[j]) * $signed(s1.elem[idx]);
      end
    end
  end

  // A row store, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NCELL; j++) begin
        a_row[j] <= '0;
      end
    end else if (wr) begin
      for (int j = 0; j < NCELL; j++) begin
        a_row[j] <= s1.elem[j];
      end
    end
  end

  always_comb begin
    dout = s2;
    for (int j = 0; j < NCELL; j++) begin
      dout.acc[j] = s2.acc[j] + {{(ACC_W - PROD_W){prod[j][PROD_W-1]}}, prod[j]};
    end
  end

  `ASSERT_NEXT(a_row_hold, !wr, $stable(a_row[0]) && $stable(a_row[NCELL-1]), "A row changed without a load")
  `ASSERT_NEXT(stall_hold, !en, $stable(s2.valid) && $stable(s1.valid), "cell advanced while stalled")
  `ASSERT_NEXT(load_stored, wr, a_row[0] == $past(s1.elem[0]), "loaded row not stored")

endmodule

// File: hw/rtl/mm4_out.sv
// Output stage: registers the final sums, scales and saturates them, and drives
// the product channel through an output register and a skid register. Depends on mm4_pkg.
`include "assert_macros.svh"

module mm4_out (
  input  logic               clk,
  input  logic               rst,
  input  mm4_pkg::mm4_item_t tail,
  output logic               en,
  mm4_out_if.source          products
);
  import mm4_pkg::*;

  mm4_item_t              s_item;
  mm4_res_t               res;
  mm4_res_t               od;
  mm4_res_t               sd;
  logic                   ov;
  logic                   sv;
  logic                   x;
  logic signed [ACC_W-1:0] scaled [NCELL];
  logic [SH_W-1:0]        sh [NCELL];
  logic [SH_W-EL_W:0]     top;

  assign en = !sv;
  assign x  = s_item.valid && (s_item.op == OP_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_item.valid <= 1'b0;
    end else if (en) begin
      s_item.valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_item.op   <= tail.op;
      s_item.row  <= tail.row;
      s_item.elem <= tail.elem;
      s_item.acc  <= tail.acc;
    end
  end

  always_comb begin
    res.row = s_item.row;
    res.sat = 1'b0;
    res.e   = '0;
    top     = '0;
    for (int j = 0; j < NCELL; j++) begin
      scaled[j] = $signed(s_item.acc[j]) >>> FRAC_BITS;
      sh[j]     = scaled[j][SH_W-1:0];
    end
    for (int j = 0; j < NCELL; j++) begin
      top = sh[j][SH_W-1:EL_W-1];
      if ((&top) || !(|top)) begin
        res.e[j] = sh[j][EL_W-1:0];
      end else begin
        res.sat  = 1'b1;
        res.e[j] = sh[j][SH_W-1] ? SAT_MIN : SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!sv) begin
      if (!ov || products.ready) begin
        ov <= x;
      end else if (x) begin
        sv <= 1'b1;
      end
    end else if (products.ready) begin
      ov <= 1'b1;
      sv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!sv) begin
      if (!ov || products.ready) begin
        od <= res;
      end else begin
        sd <= res;
      end
    end else if (products.ready) begin
      od <= sd;
    end
  end

  assign products.valid     = ov;
  assign products.out_row   = od.row;
  assign products.out_e0    = od.e[0];
  assign products.out_e1    = od.e[1];
  assign products.out_e2    = od.e[2];
  assign products.out_e3    = od.e[3];
  assign products.saturated = od.sat;

  `ASSERT_IMPL(skid_needs_out, sv, ov, "skid full while output register empty")
  `ASSERT_NEXT(skid_fill, !sv && ov && !products.ready && x, sv, "result lost on stall")
  `ASSERT_NEXT(skid_drain, sv && products.ready, ov && !sv, "skid did not drain")

endmodule

// File: hw/rtl/matrix4x4_multiply_core.sv
// Top level of the 4x4 matrix multiply core: a chain of row cells and the output stage.
// Depends on mm4_pkg, mm4_if, mm4_cell and mm4_out.
//
// Use: items arrive on the rows channel. operation 0 loads row row_index of
// matrix A from in_e0..in_e3; it gives no product item. operation 1 carries one
// row of B; the product row out[j] = sum_k A[k][j] * B[k], shifted right by 16
// with rounding toward minus infinity and saturated to 32 bits, leaves on the
// products channel with out_row = row_index and saturated set if any column clipped.
// Pipeline: two stages per cell, one sum stage and one output register; each
// cell has its own four 32x32 multipliers.
// Throughput: one item per cycle while rows.ready is high.
// A load takes effect for every item accepted after it.
// Reset: matrix A is cleared to zero, the pipeline empties, rows.ready is high
// in the first cycle after reset.
// Stall: a held result waits in the output register; one more result goes into a
// skid register, and only then does rows.ready drop and the whole chain hold.

module matrix4x4_multiply_core (
  input  logic      clk,
  input  logic      rst,
  mm4_in_if.sink    rows,
  mm4_out_if.source products
);
  import mm4_pkg::*;

  mm4_item_t          chain [NCELL+1];
  logic               en;
  logic [EL_W-1:0]    e_all [NFIELD];

  assign rows.ready = en;

  assign e_all[0] = rows.in_e0;
  assign e_all[1] = rows.in_e1;
  assign e_all[2] = rows.in_e2;
  assign e_all[3] = rows.in_e3;

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = rows.valid;
    chain[0].op    = op_t'(rows.operation);
    chain[0].row   = rows.row_index;
    for (int j = 0; j < NCELL; j++) begin
      chain[0].elem[j] = e_all[j];
    end
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    mm4_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .idx  (CIDX_W'(k)),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  mm4_out u_out (
    .clk      (clk),
    .rst      (rst),
    .tail     (chain[NCELL]),
    .en       (en),
    .products (products)
  );

endmodule

// File: bench/matrix4x4_multiply_core_test.sv
`timescale 1ns / 1ps
// Testbench of matrix4x4_multiply_core: row loads and row multiplies against a predictor.
// Depends on mm4_pkg, mm4_if and the core; needs nothing else to run.
module matrix4x4_multiply_core_test;
  import mm4_pkg::*;

  localparam int LATENCY = 10;

  typedef struct {
    op_t                op;
    logic [1:0]         row;
    logic signed [31:0] el [4];
  } row_item_t;

  logic clk;
  logic rst;

  mm4_in_if  rows_ch ();
  mm4_out_if prod_ch ();

  matrix4x4_multiply_core dut (
    .clk      (clk),
    .rst      (rst),
    .rows     (rows_ch.sink),
    .products (prod_ch.source)
  );

  logic signed [31:0] a_rows [4][4];
  mm4_res_t           pending_products [$];
  mm4_res_t           oldest;
  int                 mismatch_count = 0;
  int                 row_idle_pct = 0;
  int                 product_stall_pct = 0;
  int                 hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic mm4_res_t product_row(logic [1:0] row, logic signed [31:0] b [4]);
    logic signed [67:0] acc;
    logic signed [67:0] shifted;
    mm4_res_t           r;
    r.row = row;
    r.sat = 1'b0;
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      for (int k = 0; k < 4; k++)
        acc = acc + a_rows[k][j] * b[k];
      shifted = acc >>> FRAC_BITS;
      if (shifted > 68'sh7FFF_FFFF) begin
        r.e[j] = SAT_MAX;
        r.sat  = 1'b1;
      end else if (shifted < -68'sh8000_0000) begin
        r.e[j] = SAT_MIN;
        r.sat  = 1'b1;
      end else begin
        r.e[j] = shifted[31:0];
      end
    end
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && prod_ch.valid && prod_ch.ready) begin
      if (pending_products.size() == 0) begin
        $error("out_row: expected no item, got row %0d", prod_ch.out_row);
        mismatch_count++;
      end else begin
        oldest = pending_products.pop_front();
        check_field("out_row", 32'(oldest.row), 32'(prod_ch.out_row));
        check_field("out_e0", oldest.e[0], prod_ch.out_e0);
        check_field("out_e1", oldest.e[1], prod_ch.out_e1);
        check_field("out_e2", oldest.e[2], prod_ch.out_e2);
        check_field("out_e3", oldest.e[3], prod_ch.out_e3);
        check_field("saturated", 32'(oldest.sat), 32'(prod_ch.saturated));
      end
    end
  end

  initial begin
    prod_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        prod_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        prod_ch.ready <= ($urandom_range(99) >= product_stall_pct);
      end
    end
  end

  task automatic send_row(op_t op, logic [1:0] row, logic signed [31:0] e0,
                          logic signed [31:0] e1, logic signed [31:0] e2,
                          logic signed [31:0] e3);
    row_item_t item;
    item.op    = op;
    item.row   = row;
    item.el[0] = e0;
    item.el[1] = e1;
    item.el[2] = e2;
    item.el[3] = e3;
    while ($urandom_range(99) < row_idle_pct) begin
      rows_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rows_ch.valid     <= 1'b1;
    rows_ch.operation <= item.op;
    rows_ch.row_index <= item.row;
    rows_ch.in_e0     <= item.el[0];
    rows_ch.in_e1     <= item.el[1];
    rows_ch.in_e2     <= item.el[2];
    rows_ch.in_e3     <= item.el[3];
    do @(posedge clk); while (!rows_ch.ready);
    if (item.op == OP_LOAD)
      a_rows[item.row] = item.el;
    else
      pending_products.push_back(product_row(item.row, item.el));
  endtask

  function automatic logic signed [31:0] random_element();
    case ($urandom_range(9)) inside
      [0:3]:   return $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
      [4:5]:   return $signed($urandom_range(0, 32'h200_0000)) - 32'sh100_0000;
      [6:7]:   return $signed($urandom());
      8: begin
        case ($urandom_range(5))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sh0;
          3:       return -32'sh1;
          4:       return 32'sh1;
          default: return 32'sh1_0000;
        endcase
      end
      default: return ($signed($urandom_range(0, 16)) - 8) <<< FRAC_BITS;
    endcase
  endfunction

  task automatic send_random_row(int load_pct);
    op_t op;
    op = ($urandom_range(99) < load_pct) ? OP_LOAD : OP_MULT;
    send_row(op, 2'($urandom_range(3)), random_element(), random_element(),
             random_element(), random_element());
  endtask

  task automatic test_cleared_store();
    send_row(OP_MULT, 2'd2, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sh1, 32'sh1_0000);
  endtask

  task automatic test_identity();
    send_row(OP_LOAD, 2'd0, 32'sh1_0000, 32'sh0, 32'sh0, 32'sh0);
    send_row(OP_LOAD, 2'd1, 32'sh0, 32'sh1_0000, 32'sh0, 32'sh0);
    send_row(OP_LOAD, 2'd2, 32'sh0, 32'sh0, 32'sh1_0000, 32'sh0);
    send_row(OP_LOAD, 2'd3, 32'sh0, 32'sh0, 32'sh0, 32'sh1_0000);
    send_row(OP_MULT, 2'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1);
    send_row(OP_MULT, 2'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1, 32'sh0);
    send_row(OP_MULT, 2'd2, 32'sh1, -32'sh1_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_row(OP_MULT, 2'd3, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678, -32'sh1);
  endtask

  task automatic test_saturation();
    send_row(OP_LOAD, 2'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_row(OP_LOAD, 2'd1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_row(OP_LOAD, 2'd2, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_row(OP_LOAD, 2'd3, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_row(OP_MULT, 2'd0, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0);
    send_row(OP_MULT, 2'd1, 32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0);
    send_row(OP_MULT, 2'd2, 32'sh0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_row(OP_MULT, 2'd3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
  endtask

  task automatic test_floor_rounding();
    send_row(OP_LOAD, 2'd0, 32'sh1, -32'sh1, 32'sh1_0000, 32'sh0);
    send_row(OP_MULT, 2'd0, -32'sh1, 32'sh0, 32'sh0, 32'sh0);
    send_row(OP_MULT, 2'd1, 32'sh1, 32'sh0, 32'sh0, 32'sh0);
  endtask

  task automatic test_random_phases();
    int idle_pct  [4] = '{0, 47, 0, 10};
    int stall_pct [4] = '{0, 0, 47, 10};
    for (int ph = 0; ph < 4; ph++) begin
      row_idle_pct      = idle_pct[ph];
      product_stall_pct = stall_pct[ph];
      for (int n = 0; n < 120; n++)
        send_random_row(25);
    end
  endtask

  task automatic test_output_hold();
    row_idle_pct      = 0;
    product_stall_pct = 0;
    hold_left         = 60;
    for (int n = 0; n < 30; n++)
      send_random_row(10);
  endtask

  initial begin
    rst                = 1'b1;
    rows_ch.valid      = 1'b0;
    rows_ch.operation  = OP_LOAD;
    rows_ch.row_index  = '0;
    rows_ch.in_e0      = '0;
    rows_ch.in_e1      = '0;
    rows_ch.in_e2      = '0;
    rows_ch.in_e3      = '0;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        a_rows[r][c] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cleared_store();
    test_identity();
    test_saturation();
    test_floor_rounding();
    test_random_phases();
    test_output_hold();

    rows_ch.valid     <= 1'b0;
    row_idle_pct      = 0;
    product_stall_pct = 0;
    while (pending_products.size() != 0)
      @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0 && pending_products.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mm4_pkg.sv
hw/rtl/mm4_if.sv
hw/rtl/mm4_cell.sv
hw/rtl/mm4_out.sv
hw/rtl/matrix4x4_multiply_core.sv
bench/matrix4x4_multiply_core_test.sv
